[design/sgik_pkg.sv]
`default_nettype none
package sgik_pkg;

    localparam int NUM_DIM_PORTS = 4;
    localparam int DEF_MAX_DIM = 4;
    localparam int DEF_BINOM_ROWS = 32;

    localparam int LEVEL_W = 3;
    localparam int INDEX_W = 6;
    localparam int DIGIT_W = 5;
    localparam int DIMS_W = 3;
    localparam int KEY_W = 40;
    localparam int SUM_W = 5;
    localparam int COEF_W = 16;
    localparam int TAB_ROWS = 32;
    localparam int TAB_COLS = 4;
    localparam int SA_W = 3;

    typedef logic [TAB_ROWS-1:0][TAB_COLS-1:0][COEF_W-1:0] t_binom_tab;

    typedef struct packed {
        logic [SA_W-1:0]   acc_shift;
        logic [COEF_W-1:0] operand;
        logic [SUM_W-1:0]  op_shift;
        logic              sub;
    } t_alu_op;

    function automatic t_binom_tab build_binom(input int rows);
        t_binom_tab tab;
        int n;
        int k;
        tab = '0;
        for (n = 0; n < TAB_ROWS; n++) begin
            tab[n][0] = COEF_W'(1);
            for (k = 1; k < TAB_COLS; k++) begin
                if (n > 0) begin
                    tab[n][k] = tab[n-1][k] + tab[n-1][k-1];
                end
            end
        end
        for (n = 0; n < TAB_ROWS; n++) begin
            if (n >= rows) begin
                tab[n] = '0;
            end
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

[design/sparse_grid_index_key_top.sv]
`default_nettype none
// channel | direction | handshake                 | payload
// cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_dims
// in      | in        | i_in_valid / o_in_ready   | i_level_0..3, i_odd_index_0..3
// out     | out       | o_out_valid / i_out_ready | o_key
//
// the result is built for one request at a time on the single shared shift and add unit
// a new request can be accepted in the cycle after the result is taken
// synchronous active-low reset returns to idle and sets dims to 2
// a held result blocks new requests until taken; configuration is always accepted
module sparse_grid_index_key_top #(
    parameter int MAX_DIM = sgik_pkg::DEF_MAX_DIM,
    parameter int BINOM_ROWS = sgik_pkg::DEF_BINOM_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sgik_pkg::DIMS_W-1:0]   i_cfg_dims,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [sgik_pkg::LEVEL_W-1:0]  i_level_0,
    input  wire logic [sgik_pkg::LEVEL_W-1:0]  i_level_1,
    input  wire logic [sgik_pkg::LEVEL_W-1:0]  i_level_2,
    input  wire logic [sgik_pkg::LEVEL_W-1:0]  i_level_3,
    input  wire logic [sgik_pkg::INDEX_W-1:0]  i_odd_index_0,
    input  wire logic [sgik_pkg::INDEX_W-1:0]  i_odd_index_1,
    input  wire logic [sgik_pkg::INDEX_W-1:0]  i_odd_index_2,
    input  wire logic [sgik_pkg::INDEX_W-1:0]  i_odd_index_3,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [sgik_pkg::KEY_W-1:0]         o_key
);
    import sgik_pkg::*;

    logic [DIMS_W-1:0]  r_dims;
    logic [LEVEL_W-1:0] lev [NUM_DIM_PORTS];
    logic [INDEX_W-1:0] idx [NUM_DIM_PORTS];

    assign o_cfg_ready = 1'b1;

    assign lev[0] = i_level_0;
    assign lev[1] = i_level_1;
    assign lev[2] = i_level_2;
    assign lev[3] = i_level_3;
    assign idx[0] = i_odd_index_0;
    assign idx[1] = i_odd_index_1;
    assign idx[2] = i_odd_index_2;
    assign idx[3] = i_odd_index_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dims <= i_cfg_dims;
        end
    end

    sgik_seq #(
        .MAX_DIM    (MAX_DIM),
        .BINOM_ROWS (BINOM_ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (r_dims),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_lev       (lev),
        .i_idx       (idx),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_key       (o_key)
    );

endmodule
`default_nettype wire

[design/sgik_alu.sv]
`default_nettype none
module sgik_alu (
    input  wire logic [sgik_pkg::KEY_W-1:0] i_acc,
    input  wire sgik_pkg::t_alu_op          i_op,
    output logic [sgik_pkg::KEY_W-1:0]      o_res
);
    import sgik_pkg::*;

    logic [KEY_W-1:0] acc_sh;
    logic [KEY_W-1:0] op_sh;

    always_comb begin
        acc_sh = i_acc << i_op.acc_shift;
        op_sh  = {{(KEY_W-COEF_W){1'b0}}, i_op.operand} << i_op.op_shift;
        if (i_op.sub) begin
            o_res = acc_sh - op_sh;
        end else begin
            o_res = acc_sh + op_sh;
        end
    end

endmodule
`default_nettype wire

[design/sgik_seq.sv]
`default_nettype none
module sgik_seq #(
    parameter int MAX_DIM = sgik_pkg::DEF_MAX_DIM,
    parameter int BINOM_ROWS = sgik_pkg::DEF_BINOM_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sgik_pkg::DIMS_W-1:0]   i_dims,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [sgik_pkg::LEVEL_W-1:0]  i_lev [sgik_pkg::NUM_DIM_PORTS],
    input  wire logic [sgik_pkg::INDEX_W-1:0]  i_idx [sgik_pkg::NUM_DIM_PORTS],
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [sgik_pkg::KEY_W-1:0]         o_key
);
    import sgik_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_IND1 = 3'd1;
    localparam logic [2:0] ST_IND2A = 3'd2;
    localparam logic [2:0] ST_IND2B = 3'd3;
    localparam logic [2:0] ST_IND3 = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    localparam t_binom_tab BINOM = build_binom(BINOM_ROWS);
    localparam logic [DIMS_W-1:0] MAX_D = DIMS_W'(MAX_DIM);

    logic [2:0]         r_state, n_state;
    logic [LEVEL_W-1:0] r_lev [NUM_DIM_PORTS];
    logic [DIGIT_W-1:0] r_dig [NUM_DIM_PORTS];
    logic [1:0]         r_dm1, n_dm1;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SUM_W-1:0]   r_run, n_run;
    logic [SUM_W-1:0]   r_s, n_s;
    logic [1:0]         r_t, n_t;
    logic [KEY_W-1:0]   r_acc, n_acc;

    logic [DIMS_W-1:0]  d_eff;
    logic [SUM_W-1:0]   run_new;
    logic [SUM_W-1:0]   tab_n;
    logic [1:0]         tab_k;
    logic [COEF_W-1:0]  coef;
    t_alu_op            alu_op;
    logic [KEY_W-1:0]   alu_res;
    logic               accept;

    sgik_alu u_alu (
        .i_acc (r_acc),
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_key       = r_acc;

    always_comb begin
        if (i_dims == '0) begin
            d_eff = DIMS_W'(1);
        end else if (i_dims > MAX_D) begin
            d_eff = MAX_D;
        end else begin
            d_eff = i_dims;
        end
    end

    always_comb begin
        run_new = r_run + SUM_W'(r_lev[r_t]);
        case (r_state)
            ST_IND2A: begin
                tab_n = SUM_W'(r_t) + run_new;
                tab_k = r_t;
            end
            ST_IND2B: begin
                tab_n = SUM_W'(r_t) + r_run;
                tab_k = r_t;
            end
            default: begin
                tab_n = SUM_W'(r_dm1) + r_s;
                tab_k = r_dm1;
            end
        endcase
        coef = BINOM[tab_n][tab_k];
    end

    always_comb begin
        alu_op.acc_shift = '0;
        alu_op.operand   = coef;
        alu_op.op_shift  = r_sum;
        alu_op.sub       = 1'b0;
        case (r_state)
            ST_IND1: begin
                alu_op.acc_shift = r_lev[r_t];
                alu_op.operand   = {{(COEF_W-DIGIT_W){1'b0}}, r_dig[r_t]};
                alu_op.op_shift  = '0;
            end
            ST_IND2B: begin
                alu_op.sub = 1'b1;
            end
            ST_IND3: begin
                alu_op.op_shift = r_s;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic [SUM_W-1:0] lsum;
        lsum    = '0;
        n_state = r_state;
        n_dm1   = r_dm1;
        n_sum   = r_sum;
        n_run   = r_run;
        n_s     = r_s;
        n_t     = r_t;
        n_acc   = r_acc;
        case (r_state)
            ST_IDLE: begin
                for (int t = 0; t < NUM_DIM_PORTS; t++) begin
                    if (DIMS_W'(t) < d_eff) begin
                        lsum = lsum + SUM_W'(i_lev[t]);
                    end
                end
                if (accept) begin
                    n_dm1   = 2'(d_eff - DIMS_W'(1));
                    n_sum   = lsum;
                    n_acc   = '0;
                    n_t     = '0;
                    n_state = ST_IND1;
                end
            end
            ST_IND1: begin
                n_acc = alu_res;
                if (r_t == r_dm1) begin
                    if (r_dm1 == 2'd0) begin
                        n_s     = '0;
                        n_state = ST_IND3;
                    end else begin
                        n_t     = 2'd1;
                        n_run   = SUM_W'(r_lev[0]);
                        n_state = ST_IND2A;
                    end
                end else begin
                    n_t = r_t + 2'd1;
                end
            end
            ST_IND2A: begin
                n_acc   = alu_res;
                n_state = ST_IND2B;
            end
            ST_IND2B: begin
                n_acc = alu_res;
                n_run = run_new;
                if (r_t == r_dm1) begin
                    n_s     = '0;
                    n_state = ST_IND3;
                end else begin
                    n_t     = r_t + 2'd1;
                    n_state = ST_IND2A;
                end
            end
            ST_IND3: begin
                if (r_s == r_sum) begin
                    n_state = ST_OUT;
                end else begin
                    n_acc = alu_res;
                    n_s   = r_s + SUM_W'(1);
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dm1 <= n_dm1;
        r_sum <= n_sum;
        r_run <= n_run;
        r_s   <= n_s;
        r_t   <= n_t;
        r_acc <= n_acc;
        if (accept) begin
            for (int t = 0; t < NUM_DIM_PORTS; t++) begin
                r_lev[t] <= i_lev[t];
                r_dig[t] <= (i_idx[t] == '0) ? '0 : DIGIT_W'((i_idx[t] - INDEX_W'(1)) >> 1);
            end
        end
    end

endmodule
`default_nettype wire

[design/sgik_checker.sv]
`default_nettype none
module sgik_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [39:0] o_key
);

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready and result valid together");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && !o_out_valid))
        else $error("request accepted but block not busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_key)))
        else $error("stalled result changed");

    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("no return to idle after result");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("reset state wrong");

endmodule

bind sparse_grid_index_key_top sgik_checker u_sgik_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_key       (o_key)
);
`default_nettype wire

[tb/tb_sparse_grid_index_key_top.sv]
`timescale 1ns / 100ps

module tb_sparse_grid_index_key_top;
    import sgik_pkg::*;

    localparam int DIM_LIMIT = DEF_MAX_DIM;
    localparam int ROW_LIMIT = DEF_BINOM_ROWS;
    localparam int LEVEL_LIMIT = 6;
    localparam int DRAIN_CYCLES = 45;
    localparam int LIMIT_CYCLES = 400000;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic [NUM_DIM_PORTS-1:0][LEVEL_W-1:0] level;
        logic [NUM_DIM_PORTS-1:0][INDEX_W-1:0] odd_index;
    } t_grid_point;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [DIMS_W-1:0]  i_cfg_dims = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [LEVEL_W-1:0] i_level_0 = '0;
    logic [LEVEL_W-1:0] i_level_1 = '0;
    logic [LEVEL_W-1:0] i_level_2 = '0;
    logic [LEVEL_W-1:0] i_level_3 = '0;
    logic [INDEX_W-1:0] i_odd_index_0 = '0;
    logic [INDEX_W-1:0] i_odd_index_1 = '0;
    logic [INDEX_W-1:0] i_odd_index_2 = '0;
    logic [INDEX_W-1:0] i_odd_index_3 = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [KEY_W-1:0]   o_key;

    logic [KEY_W-1:0]   expected_keys[$];
    logic [DIMS_W-1:0]  dims_shadow = DIMS_W'(2);
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 29;
    int                 rx_idle_pct = 84;
    int                 rx_hold_left = 0;

    sparse_grid_index_key_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_dims    (i_cfg_dims),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_level_0     (i_level_0),
        .i_level_1     (i_level_1),
        .i_level_2     (i_level_2),
        .i_level_3     (i_level_3),
        .i_odd_index_0 (i_odd_index_0),
        .i_odd_index_1 (i_odd_index_1),
        .i_odd_index_2 (i_odd_index_2),
        .i_odd_index_3 (i_odd_index_3),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_key         (o_key)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] binom_coef(input int n, input int k);
        logic [63:0] c;
        int kk;
        int i;
        c = 64'd1;
        kk = k;
        if (n >= ROW_LIMIT || kk > n) begin
            return 64'd0;
        end
        if (kk > n - kk) begin
            kk = n - kk;
        end
        for (i = 1; i <= kk; i++) begin
            c = c * 64'(n - kk + i) / 64'(i);
        end
        return c;
    endfunction

    function automatic logic [KEY_W-1:0] predict_key(input logic [DIMS_W-1:0] dims_reg,
                                                     input t_grid_point p);
        int d;
        int t;
        int s;
        int sum;
        int digit;
        logic [63:0] ind1;
        logic [63:0] ind2;
        logic [63:0] ind3;
        logic [63:0] prior;
        logic [KEY_W-1:0] key;
        d = int'(dims_reg);
        if (d == 0) begin
            d = 1;
        end
        if (d > DIM_LIMIT) begin
            d = DIM_LIMIT;
        end
        ind1 = '0;
        ind2 = '0;
        ind3 = '0;
        for (t = 0; t < d; t++) begin
            digit = (p.odd_index[t] == '0) ? 0 : (int'(p.odd_index[t]) - 1) / 2;
            ind1 = (ind1 << p.level[t]) + 64'(digit);
        end
        sum = int'(p.level[0]);
        for (t = 1; t < d; t++) begin
            prior = binom_coef(t + sum, t);
            sum += int'(p.level[t]);
            ind2 = ind2 + binom_coef(t + sum, t) - prior;
        end
        ind2 = ind2 << sum;
        for (s = 0; s < sum; s++) begin
            ind3 += binom_coef(d - 1 + s, d - 1) << s;
        end
        key = KEY_W'(ind1 + ind2 + ind3);
        return key;
    endfunction

    function automatic t_grid_point make_point(input int l0, input int l1, input int l2,
                                               input int l3, input int j0, input int j1,
                                               input int j2, input int j3);
        t_grid_point p;
        p.level[0] = LEVEL_W'(l0);
        p.level[1] = LEVEL_W'(l1);
        p.level[2] = LEVEL_W'(l2);
        p.level[3] = LEVEL_W'(l3);
        p.odd_index[0] = INDEX_W'(j0);
        p.odd_index[1] = INDEX_W'(j1);
        p.odd_index[2] = INDEX_W'(j2);
        p.odd_index[3] = INDEX_W'(j3);
        return p;
    endfunction

    function automatic t_grid_point random_point(input bit well_formed);
        t_grid_point p;
        int t;
        int lev;
        int radix;
        for (t = 0; t < NUM_DIM_PORTS; t++) begin
            if (well_formed) begin
                lev = $urandom_range(LEVEL_LIMIT, 0);
                radix = 1 << lev;
                if (radix > 32) begin
                    radix = 32;
                end
                p.level[t] = LEVEL_W'(lev);
                p.odd_index[t] = INDEX_W'(2 * $urandom_range(radix - 1, 0) + 1);
            end else begin
                p.level[t] = LEVEL_W'($urandom_range(7, 0));
                p.odd_index[t] = INDEX_W'($urandom_range(63, 0));
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // one request per call, expectation recorded at acceptance
    task automatic send_point(input t_grid_point p);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_level_0     <= p.level[0];
        i_level_1     <= p.level[1];
        i_level_2     <= p.level[2];
        i_level_3     <= p.level[3];
        i_odd_index_0 <= p.odd_index[0];
        i_odd_index_1 <= p.odd_index[1];
        i_odd_index_2 <= p.odd_index[2];
        i_odd_index_3 <= p.odd_index[3];
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        expected_keys = {expected_keys, predict_key(dims_shadow, p)};
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_keys.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(input int value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_dims  <= DIMS_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        dims_shadow = DIMS_W'(value);
        i_cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (expected_keys.size() == 0) begin
                report_mismatch($sformatf("unexpected key %h", o_key));
            end else begin
                if (o_key !== expected_keys[0]) begin
                    report_mismatch($sformatf("key %h, want %h", o_key, expected_keys[0]));
                end
                void'(expected_keys.pop_front());
            end
        end
    end

    // receiver ready and long hold
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_sparse_grid_index_key_top: FAIL");
        $finish;
    end

    task automatic test_reset_dims();
        send_point(make_point(2, 3, 7, 7, 3, 5, 63, 63));
        send_point(make_point(0, 6, 0, 0, 1, 63, 0, 0));
        wait_drained();
    endtask

    task automatic test_extremes();
        write_dims(4);
        send_point(make_point(0, 0, 0, 0, 1, 1, 1, 1));
        send_point(make_point(7, 7, 7, 7, 63, 63, 63, 63));
        send_point(make_point(6, 6, 6, 6, 63, 1, 63, 1));
        // zero index
        send_point(make_point(3, 2, 1, 0, 0, 0, 0, 0));
        // even index
        send_point(make_point(3, 3, 3, 3, 2, 4, 6, 8));
        // digit beyond its radix
        send_point(make_point(0, 1, 0, 2, 63, 63, 63, 63));
        send_point(make_point(5, 0, 4, 2, 21, 1, 13, 7));
        wait_drained();
    endtask

    task automatic test_dims_range();
        int k;
        int v;
        for (k = 0; k < 6; k++) begin
            case (k)
                0: v = 0;
                1: v = 1;
                2: v = 3;
                3: v = 5;
                4: v = 6;
                default: v = 7;
            endcase
            write_dims(v);
            send_point(make_point(7, 7, 7, 7, 63, 62, 61, 60));
            send_point(make_point(1, 6, 2, 5, 1, 41, 3, 17));
        end
        wait_drained();
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_dims(3);
        @(negedge i_clk);
        rx_hold_left = STALL_CYCLES;
        @(posedge i_clk);
        repeat (12) send_point(random_point(1'b1));
        wait_drained();
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct,
                                    input logic [3:0][DIMS_W-1:0] dims_set);
        int k;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (k = 0; k < 4; k++) begin
            write_dims(int'(dims_set[k]));
            repeat (33) send_point(random_point($urandom_range(99, 0) < 80));
        end
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_dims();
        test_extremes();
        test_dims_range();
        test_output_stall();
        run_random_phase(29, 84, {3'd4, 3'd3, 3'd2, 3'd1});
        run_random_phase(84, 29, {3'd3, 3'd7, 3'd0, 3'd4});
        run_random_phase(0, 0, {3'd4, 3'd1, 3'd5, 3'd2});
        if (error_count == 0) begin
            $display("tb_sparse_grid_index_key_top: PASS");
        end else begin
            $display("tb_sparse_grid_index_key_top: FAIL");
        end
        $finish;
    end

endmodule
